### hdl/ldp_pkg.sv
// Package for the LDP Hello TLV parser: phase and status codes, TLV constants
// and the result word type. Depends on nothing; every module file imports it.
package ldp_pkg;

  localparam logic [15:0] TYPE_HELLO_PARAMS = 16'h0400;
  localparam logic [15:0] TYPE_XPORT_ADDR   = 16'h0401;
  localparam logic [15:0] TYPE_CFG_SEQ      = 16'h0402;
  localparam logic [15:0] U_BIT_MASK        = 16'h8000;
  localparam logic [15:0] HDR_BYTES         = 16'd4;
  localparam logic [15:0] COMMON_TLV_LEN    = 16'd8;
  localparam logic [15:0] OPT_VALUE_LEN     = 16'd4;
  localparam logic [15:0] HOLD_FLOOR_RST    = 16'd3;

  typedef enum logic [3:0] {
    PH_COMMON = 4'b0001,
    PH_HDR    = 4'b0010,
    PH_VALUE  = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_CTYPE   = 3'd2,
    ST_CLEN    = 3'd3,
    ST_HOLD    = 3'd4,
    ST_OLEN    = 3'd5,
    ST_UNKNOWN = 3'd6,
    ST_TRAIL   = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] holdtime;
    logic [15:0] hello_flags;
    logic [31:0] xport_addr;
    logic [31:0] config_seq;
  } ldp_result_t;

endpackage

### hdl/ldp_if.sv
// Valid/ready channel interfaces for the LDP Hello parser: body bytes in and
// parse results out. Depends on nothing.
interface ldp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ldp_hello_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] holdtime;
  logic [15:0] hello_flags;
  logic [31:0] xport_addr;
  logic [31:0] config_seq;

  modport source (output valid, output status, output holdtime, output hello_flags,
                  output xport_addr, output config_seq, input ready);
  modport sink   (input valid, input status, input holdtime, input hello_flags,
                  input xport_addr, input config_seq, output ready);
endinterface

### hdl/ldp_in_stage.sv
// Input register for the LDP Hello parser: holds one body word until the
// parse stage takes it. Depends on ldp_pkg only for the house import.
module ldp_in_stage
  import ldp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_byte_o,
  output logic       last_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;

  // The register may refill in the same cycle as it is emptied.
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o     = valid_q;
  assign data_byte_o = data_q;
  assign last_byte_o = last_q;

endmodule

### hdl/ldp_parse.sv
// Parse stage of the LDP Hello parser: TLV state registers and the combinational
// update for each body word. Depends on ldp_pkg.
module ldp_parse
  import ldp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] hold_floor_i,
  output logic        result_valid_o,
  output ldp_result_t result_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] type_q, type_d;
  logic [15:0] length_q, length_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] hold_q, hold_d;
  logic [15:0] flags_q, flags_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] seq_q, seq_d;
  status_e     error_q, error_d;
  logic [15:0] count_inc;
  status_e     status;

  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    type_d   = type_q;
    length_d = length_q;
    shift_d  = shift_q;
    hold_d   = hold_q;
    flags_d  = flags_q;
    addr_d   = addr_q;
    seq_d    = seq_q;
    error_d  = error_q;
    status   = ST_OK;

    if (error_q == ST_OK) begin
      case (phase_q)
        PH_COMMON: begin
          case (count_q[2:1])
            2'd0:    type_d   = {type_q[7:0], data_byte_i};
            2'd1:    length_d = {length_q[7:0], data_byte_i};
            2'd2:    hold_d   = {hold_q[7:0], data_byte_i};
            default: flags_d  = {flags_q[7:0], data_byte_i};
          endcase
          count_d = count_inc;
          if (count_inc == COMMON_TLV_LEN) begin
            count_d = '0;
            if (type_d != TYPE_HELLO_PARAMS) begin
              error_d = ST_CTYPE;
              phase_d = PH_FAIL;
            end else if (length_d != HDR_BYTES) begin
              error_d = ST_CLEN;
              phase_d = PH_FAIL;
            end else if (hold_d != '0 && hold_d < hold_floor_i) begin
              error_d = ST_HOLD;
              phase_d = PH_FAIL;
            end else begin
              phase_d  = PH_HDR;
              type_d   = '0;
              length_d = '0;
            end
          end
        end
        PH_HDR: begin
          if (count_q < 16'd2) begin
            type_d = {type_q[7:0], data_byte_i};
          end else begin
            length_d = {length_q[7:0], data_byte_i};
          end
          count_d = count_inc;
          if (count_inc == HDR_BYTES) begin
            count_d = '0;
            shift_d = '0;
            if ((type_d == TYPE_XPORT_ADDR || type_d == TYPE_CFG_SEQ) &&
                length_d != OPT_VALUE_LEN) begin
              error_d = ST_OLEN;
              phase_d = PH_FAIL;
            end else if (type_d != TYPE_XPORT_ADDR && type_d != TYPE_CFG_SEQ &&
                         (type_d & U_BIT_MASK) == '0) begin
              error_d = ST_UNKNOWN;
              phase_d = PH_FAIL;
            end else if (length_d == '0) begin
              // An empty skippable TLV is finished as soon as its header is.
              type_d = '0;
            end else begin
              phase_d = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          shift_d = {shift_q[23:0], data_byte_i};
          count_d = count_inc;
          if (count_inc >= length_q) begin
            if (type_q == TYPE_XPORT_ADDR) begin
              addr_d = shift_d;
            end else if (type_q == TYPE_CFG_SEQ) begin
              seq_d = shift_d;
            end
            count_d  = '0;
            shift_d  = '0;
            type_d   = '0;
            length_d = '0;
            phase_d  = PH_HDR;
          end
        end
        default: ;
      endcase
    end

    if (error_d != ST_OK) begin
      status = error_d;
    end else if (phase_d == PH_COMMON) begin
      status = ST_SHORT;
    end else if ((phase_d == PH_HDR && count_d != '0) || phase_d == PH_VALUE) begin
      status = ST_TRAIL;
    end else begin
      status = ST_OK;
    end
  end

  assign result_valid_o = step_i && last_byte_i;

  always_comb begin
    result_o        = '0;
    result_o.status = status;
    if (status == ST_OK) begin
      result_o.holdtime    = hold_d;
      result_o.hello_flags = flags_d;
      result_o.xport_addr  = addr_d;
      result_o.config_seq  = seq_d;
    end
  end

  // The message state returns to its reset value after each last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_COMMON;
      count_q  <= '0;
      type_q   <= '0;
      length_q <= '0;
      shift_q  <= '0;
      hold_q   <= '0;
      flags_q  <= '0;
      addr_q   <= '0;
      seq_q    <= '0;
      error_q  <= ST_OK;
    end else if (step_i) begin
      if (last_byte_i) begin
        phase_q  <= PH_COMMON;
        count_q  <= '0;
        type_q   <= '0;
        length_q <= '0;
        shift_q  <= '0;
        hold_q   <= '0;
        flags_q  <= '0;
        addr_q   <= '0;
        seq_q    <= '0;
        error_q  <= ST_OK;
      end else begin
        phase_q  <= phase_d;
        count_q  <= count_d;
        type_q   <= type_d;
        length_q <= length_d;
        shift_q  <= shift_d;
        hold_q   <= hold_d;
        flags_q  <= flags_d;
        addr_q   <= addr_d;
        seq_q    <= seq_d;
        error_q  <= error_d;
      end
    end
  end

endmodule

### hdl/ldp_out_stage.sv
// Result register for the LDP Hello parser: holds one result word until the
// consumer takes it. Depends on ldp_pkg for the result type.
module ldp_out_stage
  import ldp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  ldp_result_t result_i,
  output logic        space_o,
  output logic        valid_o,
  input  logic        ready_i,
  output ldp_result_t result_o
);

  logic        valid_q, valid_d;
  ldp_result_t result_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### hdl/ldp_hello_tlv_parser.sv
// LDP Hello message body parser, one body word per cycle.
// Result path: a last word waits in the input register, is parsed into the
// result register when the parse stage steps, and is offered from there.
// Throughput: one word per cycle; the parse stage stalls only while the result
// register is full and not being taken. Reset is asynchronous, active low; it
// clears all message state and sets the minimum holdtime to 3.
module ldp_hello_tlv_parser
  import ldp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ldp_byte_if.sink    byte_i,
  ldp_hello_if.source result_o
);

  logic [15:0] hold_floor_q;
  logic        in_valid;
  logic [7:0]  in_data;
  logic        in_last;
  logic        step;
  logic        out_space;
  logic        res_valid;
  ldp_result_t res_next;
  ldp_result_t res_held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_floor_q <= HOLD_FLOOR_RST;
    end else if (cfg_we_i) begin
      hold_floor_q <= cfg_wdata_i;
    end
  end

  // A word is parsed only when the result register could take its result.
  assign step = in_valid && out_space;

  ldp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (byte_i.valid),
    .ready_o     (byte_i.ready),
    .data_byte_i (byte_i.data_byte),
    .last_byte_i (byte_i.last_byte),
    .take_i      (step),
    .valid_o     (in_valid),
    .data_byte_o (in_data),
    .last_byte_o (in_last)
  );

  ldp_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (in_data),
    .last_byte_i    (in_last),
    .hold_floor_i   (hold_floor_q),
    .result_valid_o (res_valid),
    .result_o       (res_next)
  );

  ldp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .result_i (res_next),
    .space_o  (out_space),
    .valid_o  (result_o.valid),
    .ready_i  (result_o.ready),
    .result_o (res_held)
  );

  assign result_o.status      = res_held.status;
  assign result_o.holdtime    = res_held.holdtime;
  assign result_o.hello_flags = res_held.hello_flags;
  assign result_o.xport_addr  = res_held.xport_addr;
  assign result_o.config_seq  = res_held.config_seq;

endmodule
